// ===== src/bpsr_pkg.sv =====
// bpsr_pkg: shared types, widths and codes of the Bezier profile segment renderer.
// Used by bpsr_eval and bezier_profile_segment_render_top; depends on nothing.
`timescale 1ns / 1ps
package bpsr_pkg;

  localparam int ROWS_DEF = 256;
  localparam int X_W      = 15;   // profile x
  localparam int ROW_W    = 8;    // row number on the ports
  localparam int NC_W     = 24;   // n^3 and the basis products
  localparam int ACC_W    = 39;   // weighted sum before the divide
  localparam int MB_W     = 17;   // multiplier b operand (3 * x)
  localparam int CFG_IW   = 2;

  // result status codes
  localparam logic [1:0] ST_OK    = 2'd0;
  localparam logic [1:0] ST_RANGE = 2'd1;
  localparam logic [1:0] ST_ORDER = 2'd2;
  localparam logic [1:0] ST_READ  = 2'd3;

  // configuration register indexes
  localparam logic [CFG_IW-1:0] CFG_MIN_X = 2'd0;
  localparam logic [CFG_IW-1:0] CFG_MAX_X = 2'd1;

  localparam logic ACT_EDIT = 1'b0;
  localparam logic ACT_READ = 1'b1;

  typedef struct packed {
    logic             action;
    logic             joint_mode;
    logic [ROW_W-1:0] first_start_row;
    logic [ROW_W-1:0] joint_row;
    logic [ROW_W-1:0] second_end_row;
    logic [X_W-1:0]   first_start_x;
    logic [X_W-1:0]   first_ctrl_a_x;
    logic [X_W-1:0]   first_ctrl_b_x;
    logic [X_W-1:0]   joint_x;
    logic [X_W-1:0]   second_ctrl_a_x;
    logic [X_W-1:0]   second_ctrl_b_x;
    logic [X_W-1:0]   second_end_x;
  } req_t;

  typedef struct packed {
    logic [1:0]       status;
    logic [X_W-1:0]   row_x;
    logic [ROW_W-1:0] fail_row;
  } res_t;

  // request to the point evaluator; operands hold while it runs
  typedef struct packed {
    logic             start;
    logic [ROW_W-1:0] k;
    logic [ROW_W-1:0] m;
    logic [NC_W-1:0]  n3;
    logic [X_W-1:0]   x0;
    logic [X_W-1:0]   x1;
    logic [X_W-1:0]   x2;
    logic [X_W-1:0]   x3;
  } eval_req_t;

  typedef struct packed {
    logic           done;
    logic [X_W-1:0] x;
  } eval_rsp_t;

  typedef enum logic [3:0] {
    S_CLEAR,
    S_IDLE,
    S_READ,
    S_SETUP,
    S_N3,
    S_ROW,
    S_WAIT,
    S_SEGEND
  } state_e;

  typedef enum logic [1:0] {
    EV_IDLE,
    EV_MUL,
    EV_DIV,
    EV_DONE
  } ev_state_e;

endpackage

// ===== src/bpsr_ram.sv =====
// bpsr_ram: generic single-port synchronous RAM with registered read.
// No dependencies.
`timescale 1ns / 1ps
module bpsr_ram #(
  parameter int WIDTH = 15,
  parameter int DEPTH = 256
) (
  input  logic                     clk_i,
  input  logic                     we_i,
  input  logic [$clog2(DEPTH)-1:0] addr_i,
  input  logic [WIDTH-1:0]         wdata_i,
  output logic [WIDTH-1:0]         rdata_o
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem[addr_i] <= wdata_i;
    end
    rdata_o <= mem[addr_i];
  end

endmodule

// ===== src/bpsr_eval.sv =====
// bpsr_eval: evaluates one curve point, sum of Bernstein terms over n^3, truncated.
// One shared 24x17 multiplier for 12 steps, then a 15-step restoring divide. Uses bpsr_pkg.
`timescale 1ns / 1ps
module bpsr_eval (
  input  logic                clk_i,
  input  logic                rst_ni,
  input  bpsr_pkg::eval_req_t req_i,
  output bpsr_pkg::eval_rsp_t rsp_o
);

  localparam int CNT_W = 4;
  localparam logic [CNT_W-1:0] MUL_LAST = 4'd11;
  localparam logic [CNT_W-1:0] DIV_LAST = 4'd14;

  bpsr_pkg::ev_state_e state_q, state_d;
  logic [CNT_W-1:0] cnt_q, cnt_d;
  logic [bpsr_pkg::NC_W-1:0]  a_q, a_d;
  logic [bpsr_pkg::ACC_W-1:0] acc_q, acc_d;
  logic [bpsr_pkg::NC_W-1:0]  rem_q, rem_d;
  logic [bpsr_pkg::X_W-1:0]   sh_q, sh_d;
  logic [bpsr_pkg::X_W-1:0]   quo_q, quo_d;

  logic [bpsr_pkg::NC_W-1:0]          mul_a;
  logic [bpsr_pkg::MB_W-1:0]          mul_b;
  logic [bpsr_pkg::NC_W+bpsr_pkg::MB_W-1:0] prod;
  logic [bpsr_pkg::ACC_W-1:0]         acc_sum;
  logic [bpsr_pkg::NC_W:0]            trial;
  logic                               fits;

  assign prod    = (bpsr_pkg::NC_W + bpsr_pkg::MB_W)'(mul_a)
                 * (bpsr_pkg::NC_W + bpsr_pkg::MB_W)'(mul_b);
  assign acc_sum = acc_q + prod[bpsr_pkg::ACC_W-1:0];
  assign trial   = {rem_q, sh_q[bpsr_pkg::X_W-1]};
  assign fits    = trial >= {1'b0, req_i.n3};

  // operand schedule: m^3*x0, 3*k*m^2*x1, k^3*x3, 3*k^2*m*x2
  always_comb begin
    mul_a = '0;
    mul_b = '0;
    case (cnt_q)
      4'd0:    begin mul_a = 24'(req_i.m); mul_b = 17'(req_i.m);        end
      4'd1:    begin mul_a = a_q;          mul_b = 17'(req_i.m);        end
      4'd2:    begin mul_a = a_q;          mul_b = 17'(req_i.x0);       end
      4'd3:    begin mul_a = 24'(req_i.k); mul_b = 17'(req_i.m);        end
      4'd4:    begin mul_a = a_q;          mul_b = 17'(req_i.m);        end
      4'd5:    begin mul_a = a_q;          mul_b = 17'(req_i.x1) * 17'd3; end
      4'd6:    begin mul_a = 24'(req_i.k); mul_b = 17'(req_i.k);        end
      4'd7:    begin mul_a = a_q;          mul_b = 17'(req_i.k);        end
      4'd8:    begin mul_a = a_q;          mul_b = 17'(req_i.x3);       end
      4'd9:    begin mul_a = 24'(req_i.k); mul_b = 17'(req_i.m);        end
      4'd10:   begin mul_a = a_q;          mul_b = 17'(req_i.k);        end
      4'd11:   begin mul_a = a_q;          mul_b = 17'(req_i.x2) * 17'd3; end
      default: begin mul_a = '0;           mul_b = '0;                  end
    endcase
  end

  always_comb begin
    state_d = state_q;
    cnt_d   = cnt_q;
    a_d     = a_q;
    acc_d   = acc_q;
    rem_d   = rem_q;
    sh_d    = sh_q;
    quo_d   = quo_q;
    unique case (state_q)
      bpsr_pkg::EV_IDLE: begin
        if (req_i.start) begin
          cnt_d   = '0;
          acc_d   = '0;
          state_d = bpsr_pkg::EV_MUL;
        end
      end
      bpsr_pkg::EV_MUL: begin
        cnt_d = cnt_q + 4'd1;
        if (cnt_q == 4'd2 || cnt_q == 4'd5 || cnt_q == 4'd8) begin
          acc_d = acc_sum;
        end else begin
          a_d = prod[bpsr_pkg::NC_W-1:0];
        end
        if (cnt_q == MUL_LAST) begin
          // quotient is below 2^15, so the top part is already below n^3
          rem_d   = acc_sum[bpsr_pkg::ACC_W-1:bpsr_pkg::X_W];
          sh_d    = acc_sum[bpsr_pkg::X_W-1:0];
          cnt_d   = '0;
          state_d = bpsr_pkg::EV_DIV;
        end
      end
      bpsr_pkg::EV_DIV: begin
        rem_d = fits ? 24'(trial - {1'b0, req_i.n3}) : trial[bpsr_pkg::NC_W-1:0];
        sh_d  = {sh_q[bpsr_pkg::X_W-2:0], 1'b0};
        quo_d = {quo_q[bpsr_pkg::X_W-2:0], fits};
        cnt_d = cnt_q + 4'd1;
        if (cnt_q == DIV_LAST) begin
          state_d = bpsr_pkg::EV_DONE;
        end
      end
      bpsr_pkg::EV_DONE: begin
        state_d = bpsr_pkg::EV_IDLE;
      end
      default: state_d = bpsr_pkg::EV_IDLE;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= bpsr_pkg::EV_IDLE;
      cnt_q   <= '0;
    end else begin
      state_q <= state_d;
      cnt_q   <= cnt_d;
    end
  end

  always_ff @(posedge clk_i) begin
    a_q   <= a_d;
    acc_q <= acc_d;
    rem_q <= rem_d;
    sh_q  <= sh_d;
    quo_q <= quo_d;
  end

  assign rsp_o.done = (state_q == bpsr_pkg::EV_DONE);
  assign rsp_o.x    = quo_q;

endmodule

// ===== src/bezier_profile_segment_render_top.sv =====
// bezier_profile_segment_render_top: profile table RAM, edit sequencer, config registers.
// Depends on bpsr_pkg, bpsr_ram and bpsr_eval.
`timescale 1ns / 1ps
// After reset the block clears its profile table, one row per cycle, with busy high
// (config writes still taken). A read returns its word through the RAM read register and
// then the result register. An edit with a bad row order is answered in the cycle after
// start. Any other edit runs two passes over the rows: a check pass that stops at the
// first row out of range, then a write pass into the table RAM. In each pass every inner
// row goes through the point evaluator (12 steps of one shared multiplier, 15 divide
// steps, hand-off). Each result word is shown for one cycle on res_valid_o and cannot be
// held off; busy is low whenever start is taken.
module bezier_profile_segment_render_top #(
  parameter int ROWS = bpsr_pkg::ROWS_DEF
) (
  input  logic                          clk_i,
  input  logic                          rst_ni,
  input  logic                          start,
  output logic                          busy,
  input  bpsr_pkg::req_t                req_i,
  output logic                          res_valid_o,
  output bpsr_pkg::res_t                res_o,
  input  logic                          cfg_valid_i,
  output logic                          cfg_ready_o,
  input  logic [bpsr_pkg::CFG_IW-1:0]   cfg_index_i,
  input  logic [bpsr_pkg::X_W-1:0]      cfg_data_i
);

  localparam int AW = $clog2(ROWS);
  localparam int XW = bpsr_pkg::X_W;
  localparam int RW = bpsr_pkg::ROW_W;

  bpsr_pkg::state_e state_q, state_d;
  bpsr_pkg::req_t   req_q, req_d;
  bpsr_pkg::res_t   res_q, res_d;
  logic             res_valid_q, res_valid_d;
  logic             pass_q, pass_d;   // 0 check, 1 write
  logic             seg_q, seg_d;
  logic [RW-1:0]    k_q, k_d;
  logic [2*RW-1:0]  nn_q, nn_d;
  logic [bpsr_pkg::NC_W-1:0] n3_q, n3_d;
  logic [AW-1:0]    clr_q, clr_d;
  logic [XW-1:0]    min_q, max_q;

  logic             ram_we;
  logic [AW-1:0]    ram_addr;
  logic [XW-1:0]    ram_wdata, ram_rdata;

  bpsr_pkg::eval_req_t ev_req;
  bpsr_pkg::eval_rsp_t ev_rsp;
  logic                ev_start;

  logic [RW-1:0] seg_r0, seg_n, row;
  logic [XW-1:0] p0, p1, p2, p3;
  logic          bad_order, x_out, xj_out;

  // current segment
  always_comb begin
    if (seg_q) begin
      seg_r0 = req_q.joint_row;
      seg_n  = req_q.second_end_row - req_q.joint_row;
      p0 = req_q.joint_x;          p1 = req_q.second_ctrl_a_x;
      p2 = req_q.second_ctrl_b_x;  p3 = req_q.second_end_x;
    end else begin
      seg_r0 = req_q.first_start_row;
      seg_n  = req_q.joint_row - req_q.first_start_row;
      p0 = req_q.first_start_x;    p1 = req_q.first_ctrl_a_x;
      p2 = req_q.first_ctrl_b_x;   p3 = req_q.joint_x;
    end
  end

  assign row = seg_r0 + k_q;
  assign bad_order = (req_i.joint_row < req_i.first_start_row)
                   || (32'(req_i.joint_row) >= ROWS)
                   || (32'(req_i.first_start_row) >= ROWS)
                   || (req_i.joint_mode && ((req_i.second_end_row < req_i.joint_row)
                       || (32'(req_i.second_end_row) >= ROWS)));
  assign x_out  = (ev_rsp.x < min_q) || (ev_rsp.x > max_q);
  assign xj_out = (req_q.joint_x < min_q) || (req_q.joint_x > max_q);

  assign ev_req.start = ev_start;
  assign ev_req.k     = k_q;
  assign ev_req.m     = seg_n - k_q;
  assign ev_req.n3    = n3_q;
  assign ev_req.x0    = p0;
  assign ev_req.x1    = p1;
  assign ev_req.x2    = p2;
  assign ev_req.x3    = p3;

  always_comb begin
    state_d      = state_q;
    req_d        = req_q;
    res_d        = res_q;
    res_valid_d  = 1'b0;
    pass_d       = pass_q;
    seg_d        = seg_q;
    k_d          = k_q;
    nn_d         = nn_q;
    n3_d         = n3_q;
    clr_d        = clr_q;
    ram_we       = 1'b0;
    ram_addr     = '0;
    ram_wdata    = '0;
    ev_start     = 1'b0;
    unique case (state_q)
      bpsr_pkg::S_CLEAR: begin
        ram_we   = 1'b1;
        ram_addr = clr_q;
        clr_d    = clr_q + 1'b1;
        if (clr_q == AW'(ROWS - 1)) begin
          state_d = bpsr_pkg::S_IDLE;
        end
      end
      bpsr_pkg::S_IDLE: begin
        if (start) begin
          req_d = req_i;
          if (req_i.action == bpsr_pkg::ACT_READ) begin
            ram_addr = AW'(req_i.first_start_row);
            state_d  = bpsr_pkg::S_READ;
          end else if (bad_order) begin
            res_valid_d = 1'b1;
            res_d       = '0;
            res_d.status = bpsr_pkg::ST_ORDER;
          end else begin
            pass_d  = 1'b0;
            seg_d   = 1'b0;
            state_d = bpsr_pkg::S_SETUP;
          end
        end
      end
      bpsr_pkg::S_READ: begin
        res_valid_d  = 1'b1;
        res_d        = '0;
        res_d.status = bpsr_pkg::ST_READ;
        if (32'(req_q.first_start_row) < ROWS) begin
          res_d.row_x = ram_rdata;
        end
        state_d = bpsr_pkg::S_IDLE;
      end
      bpsr_pkg::S_SETUP: begin
        nn_d    = (2*RW)'(seg_n) * (2*RW)'(seg_n);
        k_d     = RW'(1);
        state_d = bpsr_pkg::S_N3;
      end
      bpsr_pkg::S_N3: begin
        n3_d    = bpsr_pkg::NC_W'(nn_q) * bpsr_pkg::NC_W'(seg_n);
        state_d = bpsr_pkg::S_ROW;
      end
      bpsr_pkg::S_ROW: begin
        if (k_q < seg_n) begin
          ev_start = 1'b1;
          state_d  = bpsr_pkg::S_WAIT;
        end else begin
          state_d = bpsr_pkg::S_SEGEND;
        end
      end
      bpsr_pkg::S_WAIT: begin
        if (ev_rsp.done) begin
          if (!pass_q && x_out) begin
            res_valid_d    = 1'b1;
            res_d          = '0;
            res_d.status   = bpsr_pkg::ST_RANGE;
            res_d.fail_row = row;
            state_d        = bpsr_pkg::S_IDLE;
          end else begin
            ram_we    = pass_q;
            ram_addr  = AW'(row);
            ram_wdata = ev_rsp.x;
            k_d       = k_q + 1'b1;
            state_d   = bpsr_pkg::S_ROW;
          end
        end
      end
      bpsr_pkg::S_SEGEND: begin
        if (!seg_q && req_q.joint_mode) begin
          if (!pass_q && xj_out) begin
            res_valid_d    = 1'b1;
            res_d          = '0;
            res_d.status   = bpsr_pkg::ST_RANGE;
            res_d.fail_row = req_q.joint_row;
            state_d        = bpsr_pkg::S_IDLE;
          end else begin
            ram_we    = pass_q;
            ram_addr  = AW'(req_q.joint_row);
            ram_wdata = req_q.joint_x;
            seg_d     = 1'b1;
            state_d   = bpsr_pkg::S_SETUP;
          end
        end else if (!pass_q) begin
          pass_d  = 1'b1;
          seg_d   = 1'b0;
          state_d = bpsr_pkg::S_SETUP;
        end else begin
          res_valid_d  = 1'b1;
          res_d        = '0;
          res_d.status = bpsr_pkg::ST_OK;
          state_d      = bpsr_pkg::S_IDLE;
        end
      end
      default: state_d = bpsr_pkg::S_IDLE;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= bpsr_pkg::S_CLEAR;
      res_valid_q <= 1'b0;
      pass_q      <= 1'b0;
      seg_q       <= 1'b0;
      clr_q       <= '0;
    end else begin
      state_q     <= state_d;
      res_valid_q <= res_valid_d;
      pass_q      <= pass_d;
      seg_q       <= seg_d;
      clr_q       <= clr_d;
    end
  end

  always_ff @(posedge clk_i) begin
    req_q <= req_d;
    res_q <= res_d;
    k_q   <= k_d;
    nn_q  <= nn_d;
    n3_q  <= n3_d;
  end

  // config registers; writes must only arrive while idle, a rule on the user that the block itself does not enforce
  assign cfg_ready_o = 1'b1;
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      min_q <= '0;
      max_q <= '1;
    end else if (cfg_valid_i) begin
      unique case (cfg_index_i)
        bpsr_pkg::CFG_MIN_X: min_q <= cfg_data_i;
        bpsr_pkg::CFG_MAX_X: max_q <= cfg_data_i;
        default: ;
      endcase
    end
  end

  bpsr_ram #(
    .WIDTH(XW),
    .DEPTH(ROWS)
  ) u_table (
    .clk_i  (clk_i),
    .we_i   (ram_we),
    .addr_i (ram_addr),
    .wdata_i(ram_wdata),
    .rdata_o(ram_rdata)
  );

  bpsr_eval u_eval (
    .clk_i (clk_i),
    .rst_ni(rst_ni),
    .req_i (ev_req),
    .rsp_o (ev_rsp)
  );

  assign busy        = (state_q != bpsr_pkg::S_IDLE);
  assign res_valid_o = res_valid_q;
  assign res_o       = res_q;

  // evaluator answers only when the sequencer waits for it
  a_eval_done: assert property (@(posedge clk_i) disable iff (!rst_ni)
    ev_rsp.done |-> state_q == bpsr_pkg::S_WAIT)
    else $error("evaluator done outside wait state");

  // table is written only by the clearing sweep or the write pass
  a_write_pass: assert property (@(posedge clk_i) disable iff (!rst_ni)
    ram_we |-> (state_q == bpsr_pkg::S_CLEAR || pass_q))
    else $error("table write during check pass");

  // a range rejection is decided in the check pass
  a_range_check: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (res_valid_o && res_o.status == bpsr_pkg::ST_RANGE) |-> !$past(pass_q))
    else $error("range reject from write pass");

endmodule
